// ===== sv/pwa_pkg.sv =====
// ----------------------------------------------------------------------------
// pwa_pkg
// Shared widths, codes, controller states and the command and status groups
// that link the averager controller to its datapath.
// ----------------------------------------------------------------------------
package pwa_pkg;

    localparam int CH_W     = 5;
    localparam int IDX_W    = 12;
    localparam int SV_W     = 16;
    localparam int GAIN_W   = 16;
    localparam int PROD_W   = SV_W + GAIN_W + 1;
    localparam int SUM_W    = 48;
    localparam int AVG_W    = 40;
    localparam int CNT_W    = 16;
    localparam int CNT_SLOTS = 1 << CH_W;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;

    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic ACT_ACCUM = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic acc_commit;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic in_read;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== sv/pwa_ram.sv =====
// ----------------------------------------------------------------------------
// pwa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pwa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/pwa_ctrl.sv =====
// ----------------------------------------------------------------------------
// pwa_ctrl
// Sequencer for the averager: clearing pass, accumulate read-modify-write,
// and the divide and output hand-off of a read.
// ----------------------------------------------------------------------------
module pwa_ctrl
    import pwa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_s_tvalid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_stat.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = i_stat.in_read ? ST_PREP : ST_ACC;
                end
            end
            ST_ACC:  n_state = ST_IDLE;
            ST_PREP: n_state = ST_DIV;
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_s_tready       = 1'b0;
        unique case (r_state)
            ST_CLEAR: o_cmd.clear_wr = 1'b1;
            ST_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = accept;
            end
            ST_ACC:  o_cmd.acc_commit = 1'b1;
            ST_PREP: o_cmd.div_init   = 1'b1;
            ST_DIV:  o_cmd.div_step   = 1'b1;
            ST_OUT:  o_cmd.out_load   = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== sv/pwa_dp.sv =====
// ----------------------------------------------------------------------------
// pwa_dp
// Datapath of the averager: sum memory, per-channel event counters,
// scaling multiplier, saturating adder, bit-serial divider and output register.
// ----------------------------------------------------------------------------
module pwa_dp
    import pwa_pkg::*;
#(
    parameter int CHANNELS    = 32,
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_action,
    input  logic [CH_W-1:0]       i_channel,
    input  logic [IDX_W-1:0]      i_sample_index,
    input  logic signed [SV_W-1:0] i_sample_value,
    input  logic [GAIN_W-1:0]     i_gain_recip,
    input  logic                  i_last_sample,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic signed [AVG_W-1:0] o_average_value,
    output logic [CNT_W-1:0]      o_event_total,
    output logic                  o_no_events
);

    localparam int DEPTH = CHANNELS * MAX_SAMPLES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [AVG_W-1:0] AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
    localparam logic [AVG_W-1:0] AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

    // Input decode
    logic          in_ch_ok;
    logic          in_idx_ok;
    logic [AW-1:0] in_addr;

    assign in_ch_ok  = 32'(i_channel) < 32'(CHANNELS);
    assign in_idx_ok = 32'(i_sample_index) < 32'(MAX_SAMPLES);
    assign in_addr   = AW'(32'(i_channel) * 32'(MAX_SAMPLES) + 32'(i_sample_index));

    // Latched transaction
    logic                    r_ch_ok;
    logic                    r_idx_ok;
    logic                    r_last;
    logic [CH_W-1:0]         r_ch;
    logic [AW-1:0]           r_addr;
    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ch_ok  <= in_ch_ok;
            r_idx_ok <= in_idx_ok;
            r_last   <= i_last_sample;
            r_ch     <= i_channel;
            r_addr   <= in_addr;
            r_prod   <= $signed({{(PROD_W-SV_W){i_sample_value[SV_W-1]}}, i_sample_value})
                      * $signed({{(PROD_W-GAIN_W){1'b0}}, i_gain_recip});
        end
    end

    // Sum memory and clearing sweep
    logic [AW-1:0]    r_clr_addr;
    logic [SUM_W-1:0] rd_data;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [SUM_W-1:0] mem_wdata;
    logic [SUM_W:0]   sum_ext;
    logic [SUM_W-1:0] sum_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_wr && !o_stat.clear_done) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    assign sum_ext = {rd_data[SUM_W-1], rd_data}
                   + {{(SUM_W+1-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_comb begin
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
            sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_ext[SUM_W-1:0];
        end
    end

    assign mem_we    = i_cmd.clear_wr || (i_cmd.acc_commit && r_ch_ok && r_idx_ok);
    assign mem_waddr = i_cmd.clear_wr ? r_clr_addr : r_addr;
    assign mem_wdata = i_cmd.clear_wr ? '0 : sum_sat;

    pwa_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_sum_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_addr (in_addr),
        .o_rd_data (rd_data)
    );

    // Event counters
    logic [CNT_W-1:0] r_cnt [CNT_SLOTS];
    logic [CNT_W-1:0] cur_cnt;

    assign cur_cnt = r_ch_ok ? r_cnt[r_ch] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CNT_SLOTS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_cmd.acc_commit && r_ch_ok && r_last && (cur_cnt != '1)) begin
            r_cnt[r_ch] <= cur_cnt + CNT_W'(1);
        end
    end

    // Restoring divider, one quotient bit per cycle
    logic [CNT_W-1:0]  r_div_cnt;
    logic              r_zero;
    logic              r_neg;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_diff;
    logic              trial_ge;

    assign trial      = {r_rem, r_quo[SUM_W-1]};
    assign trial_diff = trial - {1'b0, r_div_cnt};
    assign trial_ge   = trial >= {1'b0, r_div_cnt};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_div_cnt <= cur_cnt;
            r_zero    <= (cur_cnt == '0) || !r_idx_ok;
            r_neg     <= rd_data[SUM_W-1];
            r_quo     <= rd_data[SUM_W-1] ? (~rd_data + SUM_W'(1)) : rd_data;
            r_rem     <= '0;
            r_step    <= '0;
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[SUM_W-2:0], trial_ge};
            r_rem  <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_step <= r_step + STEP_W'(1);
        end
    end

    // Sign restore and clamp to the output width
    logic [AVG_W-1:0] avg_next;

    always_comb begin
        priority if (r_zero) begin
            avg_next = '0;
        end else if (!r_neg) begin
            avg_next = (|r_quo[SUM_W-1:AVG_W-1]) ? AVG_MAX : r_quo[AVG_W-1:0];
        end else if ((|r_quo[SUM_W-1:AVG_W])
                     || (r_quo[AVG_W-1] && (|r_quo[AVG_W-2:0]))) begin
            avg_next = AVG_MIN;
        end else begin
            avg_next = ~r_quo[AVG_W-1:0] + AVG_W'(1);
        end
    end

    // Output register
    logic                   r_out_valid;
    logic [AVG_W-1:0]       r_out_avg;
    logic [CNT_W-1:0]       r_out_cnt;
    logic                   r_out_none;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_avg  <= avg_next;
            r_out_cnt  <= r_div_cnt;
            r_out_none <= r_div_cnt == '0;
        end
    end

    assign o_m_tvalid      = r_out_valid;
    assign o_average_value = $signed(r_out_avg);
    assign o_event_total   = r_out_cnt;
    assign o_no_events     = r_out_none;

    assign o_stat.clear_done = r_clr_addr == AW'(DEPTH - 1);
    assign o_stat.in_read    = i_action == ACT_READ;
    assign o_stat.div_done   = r_step == STEP_W'(DIV_STEPS - 1);
    assign o_stat.out_free   = !r_out_valid || i_m_tready;

endmodule

// ===== sv/per_channel_waveform_averager_core.sv =====
// ----------------------------------------------------------------------------
// per_channel_waveform_averager_core
// Per-channel coherent waveform averager: accumulates gain-scaled samples per
// channel and sample position, counts events, and returns averages on request.
// ----------------------------------------------------------------------------
// After reset the block sweeps its sum memory to zero, one entry per cycle,
// over all CHANNELS * MAX_SAMPLES entries (131072 with the defaults); no
// transaction is taken until the sweep ends. An accumulate transaction is a
// read-modify-write of the single-write-port sum memory. A read transaction
// fetches the sum, sets up the divider, runs the bit-serial divide of the
// 48-bit sum by the event count, and hands the result to the output
// register once that register no longer waits on the downstream side.
// Only read transactions produce an output transaction.
// ----------------------------------------------------------------------------
module per_channel_waveform_averager_core
    import pwa_pkg::*;
#(
    parameter int CHANNELS    = 32,
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // channel, sample_index, sample_value, gain_recip, zero fill
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // action
    input  logic                  i_s_tuser,
    input  logic                  i_s_tlast,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // average_value, event_total
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // no_events
    output logic                  o_m_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready
);

    localparam int IDX_LO  = CH_W;
    localparam int SV_LO   = IDX_LO + IDX_W;
    localparam int GAIN_LO = SV_LO + SV_W;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    logic signed [AVG_W-1:0] average_value;
    logic [CNT_W-1:0]        event_total;

    pwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pwa_dp #(
        .CHANNELS    (CHANNELS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_action        (i_s_tuser),
        .i_channel       (i_s_tdata[CH_W-1:0]),
        .i_sample_index  (i_s_tdata[SV_LO-1:IDX_LO]),
        .i_sample_value  ($signed(i_s_tdata[GAIN_LO-1:SV_LO])),
        .i_gain_recip    (i_s_tdata[GAIN_LO+GAIN_W-1:GAIN_LO]),
        .i_last_sample   (i_s_tlast),
        .i_m_tready      (i_m_tready),
        .o_m_tvalid      (o_m_tvalid),
        .o_average_value (average_value),
        .o_event_total   (event_total),
        .o_no_events     (o_m_tuser)
    );

    assign o_m_tdata = {event_total, average_value};

endmodule
